// ===== src/mcsp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and tables for the MAC command stream parser.
// No dependencies; imported by every module of the block.
package mcsp_pkg;

    localparam int ANSWER_DEPTH = 32;
    localparam int FILL_W       = $clog2(ANSWER_DEPTH + 1);
    localparam int ADDR_W       = $clog2(ANSWER_DEPTH);
    localparam int ACC_W        = 40;

    localparam logic [7:0] CID_LINK_CHECK  = 8'h02;
    localparam logic [7:0] CID_DEV_STATUS  = 8'h06;
    localparam logic [7:0] CID_NEW_CHANNEL = 8'h07;
    localparam logic [7:0] CID_RX_TIMING   = 8'h08;
    localparam logic [7:0] CID_DEVICE_TIME = 8'h0D;

    localparam logic [7:0] ANS_BATTERY_UNKNOWN = 8'hFF;
    localparam logic [7:0] ANS_NEW_CHANNEL_OK  = 8'((1 << 0) | (1 << 1));

    typedef enum logic [2:0] {
        KIND_LINK_CHECK  = 3'd0,
        KIND_NEW_CHANNEL = 3'd1,
        KIND_RX_TIMING   = 3'd2,
        KIND_DEVICE_TIME = 3'd3,
        KIND_ANSWER      = 3'd4,
        KIND_DONE        = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_COLLECT = 2'd1,
        PH_ABORT   = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PARSE,
        ST_EVENT,
        ST_PUSH,
        ST_RDREQ,
        ST_RDOUT,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic parse;
        logic load_event;
        logic push;
        logic read;
        logic load_answer;
        logic load_done;
    } ctrl_cmd_t;

    typedef struct packed {
        logic has_event;
        logic push_more;
        logic frame_last;
        logic aborted;
        logic fill_zero;
        logic rd_last;
        logic out_free;
    } ctrl_sts_t;

    // total length including identifier; 0 = unknown identifier
    function automatic logic [2:0] cmd_length(input logic [7:0] cid);
        logic [2:0] len;
        case (cid)
            8'h01: len = 3'd2;
            8'h02: len = 3'd3;
            8'h03: len = 3'd5;
            8'h04: len = 3'd2;
            8'h05: len = 3'd5;
            8'h06: len = 3'd1;
            8'h07: len = 3'd6;
            8'h08: len = 3'd2;
            8'h09: len = 3'd2;
            8'h0A: len = 3'd5;
            8'h0B: len = 3'd2;
            8'h0C: len = 3'd2;
            8'h0D: len = 3'd6;
            8'h0E: len = 3'd3;
            8'h0F: len = 3'd2;
            8'h10: len = 3'd1;
            8'h11: len = 3'd5;
            8'h12: len = 3'd4;
            8'h13: len = 3'd4;
            8'h20: len = 3'd2;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [1:0] answer_len(input logic [7:0] cid);
        logic [1:0] n;
        case (cid)
            CID_DEV_STATUS:  n = 2'd3;
            CID_NEW_CHANNEL: n = 2'd2;
            CID_RX_TIMING:   n = 2'd1;
            default:         n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== src/mcsp_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencing state machine: byte capture, parse, event, answer push, drain, done.
// Depends on mcsp_pkg.
module mcsp_ctrl
    import mcsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  ctrl_sts_t  sts,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_PARSE;
                end
            end
            ST_PARSE:
            begin
                cmd.parse  = 1'b1;
                state_next = ST_EVENT;
            end
            ST_EVENT:
            begin
                if (!sts.has_event)
                begin
                    state_next = ST_PUSH;
                end
                else if (sts.out_free)
                begin
                    cmd.load_event = 1'b1;
                    state_next     = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (sts.push_more)
                begin
                    cmd.push = 1'b1;
                end
                else if (sts.frame_last)
                begin
                    if (!sts.aborted && !sts.fill_zero)
                    begin
                        state_next = ST_RDREQ;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RDREQ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_RDOUT;
            end
            ST_RDOUT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_answer = 1'b1;
                    state_next      = sts.rd_last ? ST_DONE : ST_RDREQ;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_done = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/mcsp_datapath.sv =====
`timescale 1ns / 1ps
// Parser state, answer buffer memory and output word register.
// Depends on mcsp_pkg; driven by mcsp_ctrl.
module mcsp_datapath
    import mcsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] s_tdata,
    input  logic        s_tlast,
    input  ctrl_cmd_t   cmd,
    output ctrl_sts_t   sts,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    logic [7:0]        byte_reg;
    logic [7:0]        snr_reg;
    logic              last_reg, last_next;
    phase_t            phase_reg, phase_next;
    logic [7:0]        cid_reg, cid_next;
    logic [2:0]        rem_reg, rem_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic              fin_reg, fin_next;
    logic [1:0]        push_idx_reg, push_idx_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              ovf_reg, ovf_next;
    logic [FILL_W-1:0] rd_idx_reg, rd_idx_next;
    logic [7:0]        rd_data_reg;
    logic [7:0]        mem [ANSWER_DEPTH];

    logic              m_tvalid_reg, m_tvalid_next;
    logic [63:0]       m_tdata_reg, m_tdata_next;
    kind_t             m_tuser_reg, m_tuser_next;
    logic              m_tlast_reg, m_tlast_next;

    logic [2:0]        len;
    logic [2:0]        rem_dec;
    logic              full;
    logic              out_free;
    logic [7:0]        push_byte;
    logic [31:0]       ev_wide;
    logic [7:0]        ev_narrow;
    logic [3:0]        ev_rmin;
    logic [3:0]        ev_rmax;
    kind_t             ev_kind;
    logic              ev_valid;
    logic [5:0]        done_cnt;

    assign len      = cmd_length(byte_reg);
    assign rem_dec  = rem_reg - 3'd1;
    assign full     = (fill_reg >= FILL_W'(ANSWER_DEPTH));
    assign out_free = !m_tvalid_reg || m_tready;
    assign done_cnt = (phase_reg == PH_ABORT) ? 6'd0 : 6'(fill_reg);

    always_comb
    begin
        ev_valid  = 1'b0;
        ev_kind   = KIND_LINK_CHECK;
        ev_wide   = '0;
        ev_narrow = '0;
        ev_rmin   = '0;
        ev_rmax   = '0;
        case (cid_reg)
            CID_LINK_CHECK:
            begin
                ev_valid  = 1'b1;
                ev_kind   = KIND_LINK_CHECK;
                ev_wide   = {24'd0, acc_reg[15:8]};
                ev_narrow = acc_reg[7:0];
            end
            CID_NEW_CHANNEL:
            begin
                ev_valid  = 1'b1;
                ev_kind   = KIND_NEW_CHANNEL;
                ev_wide   = {8'd0, acc_reg[15:8], acc_reg[23:16], acc_reg[31:24]};
                ev_narrow = acc_reg[39:32];
                ev_rmin   = acc_reg[3:0];
                ev_rmax   = acc_reg[7:4];
            end
            CID_RX_TIMING:
            begin
                ev_valid = 1'b1;
                ev_kind  = KIND_RX_TIMING;
                ev_wide  = {28'd0, acc_reg[3:0]};
            end
            CID_DEVICE_TIME:
            begin
                ev_valid  = 1'b1;
                ev_kind   = KIND_DEVICE_TIME;
                ev_wide   = {acc_reg[15:8], acc_reg[23:16], acc_reg[31:24], acc_reg[39:32]};
                ev_narrow = acc_reg[7:0];
            end
            default:
            begin
                ev_valid = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        push_byte = cid_reg;
        case (cid_reg)
            CID_DEV_STATUS:
            begin
                case (push_idx_reg)
                    2'd0:    push_byte = CID_DEV_STATUS;
                    2'd1:    push_byte = ANS_BATTERY_UNKNOWN;
                    default: push_byte = snr_reg;
                endcase
            end
            CID_NEW_CHANNEL:
            begin
                push_byte = (push_idx_reg == 2'd0) ? CID_NEW_CHANNEL : ANS_NEW_CHANNEL_OK;
            end
            default:
            begin
                push_byte = cid_reg;
            end
        endcase
    end

    always_comb
    begin
        sts.has_event  = fin_reg && ev_valid;
        sts.push_more  = fin_reg && (push_idx_reg < answer_len(cid_reg));
        sts.frame_last = last_reg;
        sts.aborted    = (phase_reg == PH_ABORT);
        sts.fill_zero  = (fill_reg == '0);
        sts.rd_last    = ((rd_idx_reg + FILL_W'(1)) == fill_reg);
        sts.out_free   = out_free;
    end

    // parser and buffer bookkeeping
    always_comb
    begin
        last_next     = last_reg;
        phase_next    = phase_reg;
        cid_next      = cid_reg;
        rem_next      = rem_reg;
        acc_next      = acc_reg;
        fin_next      = fin_reg;
        push_idx_next = push_idx_reg;
        fill_next     = fill_reg;
        ovf_next      = ovf_reg;
        rd_idx_next   = rd_idx_reg;

        if (cmd.capture)
        begin
            last_next = s_tlast;
        end

        if (cmd.parse)
        begin
            fin_next      = 1'b0;
            push_idx_next = '0;
            rd_idx_next   = '0;
            case (phase_reg)
                PH_COLLECT:
                begin
                    acc_next = {acc_reg[ACC_W-9:0], byte_reg};
                    rem_next = rem_dec;
                    if (rem_dec == 3'd0)
                    begin
                        phase_next = PH_IDLE;
                        fin_next   = 1'b1;
                    end
                end
                PH_ABORT:
                begin
                    phase_next = PH_ABORT;
                end
                default:
                begin
                    cid_next = byte_reg;
                    acc_next = '0;
                    if (len == 3'd0)
                    begin
                        phase_next = PH_ABORT;
                        rem_next   = 3'd0;
                    end
                    else if (len == 3'd1)
                    begin
                        phase_next = PH_IDLE;
                        rem_next   = 3'd0;
                        fin_next   = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_COLLECT;
                        rem_next   = len - 3'd1;
                    end
                end
            endcase
        end

        if (cmd.push)
        begin
            push_idx_next = push_idx_reg + 2'd1;
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end

        if (cmd.load_answer)
        begin
            rd_idx_next = rd_idx_reg + FILL_W'(1);
        end

        if (cmd.load_done)
        begin
            fin_next   = 1'b0;
            phase_next = PH_IDLE;
            cid_next   = '0;
            rem_next   = '0;
            acc_next   = '0;
            fill_next  = '0;
            ovf_next   = 1'b0;
        end
    end

    // output word register
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        if (cmd.load_event)
        begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = ev_kind;
            m_tdata_next  = {16'd0, ev_rmax, ev_rmin, ev_narrow, ev_wide};
            m_tlast_next  = !last_reg;
        end
        else if (cmd.load_answer)
        begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = KIND_ANSWER;
            m_tdata_next  = {8'd0, rd_data_reg, 48'd0};
            m_tlast_next  = 1'b0;
        end
        else if (cmd.load_done)
        begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = KIND_DONE;
            m_tdata_next  = {ovf_reg, (phase_reg == PH_ABORT), done_cnt, 56'd0};
            m_tlast_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg     <= 1'b0;
            phase_reg    <= PH_IDLE;
            cid_reg      <= '0;
            rem_reg      <= '0;
            acc_reg      <= '0;
            fin_reg      <= 1'b0;
            push_idx_reg <= '0;
            fill_reg     <= '0;
            ovf_reg      <= 1'b0;
            rd_idx_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            last_reg     <= last_next;
            phase_reg    <= phase_next;
            cid_reg      <= cid_next;
            rem_reg      <= rem_next;
            acc_reg      <= acc_next;
            fin_reg      <= fin_next;
            push_idx_reg <= push_idx_next;
            fill_reg     <= fill_next;
            ovf_reg      <= ovf_next;
            rd_idx_reg   <= rd_idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            byte_reg <= s_tdata[7:0];
            snr_reg  <= s_tdata[15:8];
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    // answer buffer
    always_ff @(posedge clk)
    begin
        if (cmd.push && !full)
        begin
            mem[fill_reg[ADDR_W-1:0]] <= push_byte;
        end
        if (cmd.read)
        begin
            rd_data_reg <= mem[rd_idx_reg[ADDR_W-1:0]];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(ANSWER_DEPTH))
        else $error("answer fill beyond buffer depth");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_event || cmd.load_answer || cmd.load_done) |-> out_free)
        else $error("output word overwritten while stalled");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_done |=> (m_tvalid_reg && m_tlast_reg && m_tuser_reg == KIND_DONE))
        else $error("done word not marked last");

    a_abort_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_done && phase_reg == PH_ABORT) |=> (m_tdata_reg[61:56] == 6'd0))
        else $error("aborted frame reports answers");

endmodule

// ===== src/mac_command_stream_parser_core.sv =====
`timescale 1ns / 1ps
// Top level of the MAC command stream parser.
// Depends on mcsp_pkg, mcsp_ctrl and mcsp_datapath.
//
// Input stream: one payload byte per word, s_tlast on the frame's final byte.
// Output stream: decoded events, buffered answer bytes and a frame done word;
// m_tlast marks the last word caused by one input byte.
// Steps per input byte: capture, parse, an event slot (it waits for a free output
// register when there is an event), then one push per answer byte (0 to 3).
// A frame-ending byte then reads out each buffered answer byte (registered buffer
// read, then output load) unless the frame was aborted, and loads the done word.
// s_tready is high only while the sequencer waits for a byte.
// Results leave through a one-word output register; a stalled m_tready holds
// the sequencer at the next output load and the word stays on the port.
// Reset clears the parser, the fill count and the output valid at once; no
// clearing pass over the answer buffer is needed, only written entries are read.
module mac_command_stream_parser_core
    import mcsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // data_byte, radio_snr
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,  // value_wide, value_narrow, rate_min, rate_max,
                                  // answer_byte, answer_count, aborted, overflowed
    output logic [2:0]  m_tuser,  // kind
    output logic        m_tlast
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    mcsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mcsp_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
